>>> hdl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// shared constants for the circular deque with cursors
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W  = 3;
    localparam int VALUE_W = 32;
    localparam int ITEM_W  = 32;

    localparam logic [KIND_W-1:0] KIND_PUT_FRONT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUT_END     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FWD_RESTART = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NEXT        = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BACK_RESTART = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PRIOR       = 3'd5;

endpackage

>>> hdl/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = cdq_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH = cdq_pkg::DEPTH_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/circular_deque_with_cursors.sv
// ----------------------------------------------------------------------------
// circular_deque_with_cursors
// ring-buffer deque with a forward and a backward cursor
// ----------------------------------------------------------------------------
// One request is taken every clock cycle (busy stays low); its result appears
// on the o_ ports with o_valid in the cycle after start, set by the
// registered read port of the element ram. Results cannot be held off, so the
// receiver must capture every cycle in which o_valid is high. Pointers, count
// and cursor flags live in registers; elements live in one ram of DEPTH
// entries that needs no clearing after reset.
module circular_deque_with_cursors #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [cdq_pkg::KIND_W-1:0]  i_kind,
    input  logic [cdq_pkg::VALUE_W-1:0] i_value,
    output logic                        busy,
    output logic                        o_valid,
    output logic [cdq_pkg::ITEM_W-1:0]  o_item_out,
    output logic                        o_finished,
    output logic [CNT_W-1:0]            o_count,
    output logic                        o_empty_get,
    output logic                        o_full_drop
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = CNT_W + 1;
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(DEPTH - 1);
    localparam logic [SUM_W-1:0]  DEPTH_S = SUM_W'(DEPTH);

    logic [ADDR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_fwd, n_fwd;
    logic              r_fwd_on, n_fwd_on;
    logic [ADDR_W-1:0] r_back, n_back;
    logic              r_back_on, n_back_on;

    logic              r_valid;
    logic              r_rd, n_rd;
    logic              r_fin, n_fin;
    logic [CNT_W-1:0]  r_cnt_out;
    logic              r_emp, n_emp;
    logic              r_full, n_full;

    logic              w_take;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic [63:0]       w_value_ext;
    logic signed [63:0] w_item_ext;

    logic [SUM_W-1:0]  w_tail_s;
    logic [SUM_W-1:0]  w_last_s;
    logic [ADDR_W-1:0] w_tail;
    logic [ADDR_W-1:0] w_last;
    logic [ADDR_W-1:0] w_head_dec;
    logic [ADDR_W-1:0] w_fwd_inc;
    logic [ADDR_W-1:0] w_back_dec;
    logic              w_is_full;
    logic              w_is_empty;

    assign busy   = 1'b0;
    assign w_take = start && !busy;

    assign w_value_ext = {{(64 - cdq_pkg::VALUE_W){1'b0}}, i_value};
    assign w_wdata     = w_value_ext[DATA_WIDTH-1:0];

    // ring arithmetic, sums stay below twice the depth
    assign w_tail_s = SUM_W'(r_head) + SUM_W'(r_count);
    assign w_last_s = w_tail_s - SUM_W'(1);
    assign w_tail   = (w_tail_s >= DEPTH_S) ? ADDR_W'(w_tail_s - DEPTH_S)
                                            : ADDR_W'(w_tail_s);
    assign w_last   = (w_last_s >= DEPTH_S) ? ADDR_W'(w_last_s - DEPTH_S)
                                            : ADDR_W'(w_last_s);

    assign w_head_dec = (r_head == '0) ? LAST_A : r_head - ADDR_W'(1);
    assign w_fwd_inc  = (r_fwd == LAST_A) ? '0 : r_fwd + ADDR_W'(1);
    assign w_back_dec = (r_back == '0) ? LAST_A : r_back - ADDR_W'(1);

    assign w_is_full  = (r_count == CNT_W'(DEPTH));
    assign w_is_empty = (r_count == '0);

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_fwd     = r_fwd;
        n_fwd_on  = r_fwd_on;
        n_back    = r_back;
        n_back_on = r_back_on;
        n_rd      = 1'b0;
        n_fin     = 1'b0;
        n_emp     = 1'b0;
        n_full    = 1'b0;
        w_we      = 1'b0;
        w_waddr   = w_tail;
        w_raddr   = r_fwd;
        unique case (i_kind)
            cdq_pkg::KIND_PUT_FRONT: begin
                if (w_is_full) begin
                    n_full = 1'b1;
                end else begin
                    n_head  = w_head_dec;
                    w_waddr = w_head_dec;
                    w_we    = w_take;
                    n_count = r_count + CNT_W'(1);
                end
            end
            cdq_pkg::KIND_PUT_END: begin
                if (w_is_full) begin
                    n_full = 1'b1;
                end else begin
                    w_waddr = w_tail;
                    w_we    = w_take;
                    n_count = r_count + CNT_W'(1);
                end
            end
            cdq_pkg::KIND_FWD_RESTART: begin
                n_fwd_on = 1'b0;
            end
            cdq_pkg::KIND_NEXT: begin
                if (w_is_empty) begin
                    n_emp = 1'b1;
                end else begin
                    n_fwd    = (!r_fwd_on || r_fwd == w_last) ? r_head : w_fwd_inc;
                    n_fwd_on = 1'b1;
                    n_rd     = 1'b1;
                    n_fin    = (n_fwd == w_last);
                    w_raddr  = n_fwd;
                end
            end
            cdq_pkg::KIND_BACK_RESTART: begin
                n_back_on = 1'b0;
            end
            cdq_pkg::KIND_PRIOR: begin
                if (w_is_empty) begin
                    n_emp = 1'b1;
                end else begin
                    n_back    = (!r_back_on || r_back == r_head) ? w_last : w_back_dec;
                    n_back_on = 1'b1;
                    n_rd      = 1'b1;
                    n_fin     = (n_back == r_head);
                    w_raddr   = n_back;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_fwd     <= '0;
            r_fwd_on  <= 1'b0;
            r_back    <= '0;
            r_back_on <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= w_take;
            if (w_take) begin
                r_head    <= n_head;
                r_count   <= n_count;
                r_fwd     <= n_fwd;
                r_fwd_on  <= n_fwd_on;
                r_back    <= n_back;
                r_back_on <= n_back_on;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rd      <= n_rd;
            r_fin     <= n_fin;
            r_cnt_out <= n_count;
            r_emp     <= n_emp;
            r_full    <= n_full;
        end
    end

    cdq_ram #(
        .WIDTH  (DATA_WIDTH),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_item_ext = 64'(signed'(w_rdata));

    assign o_valid     = r_valid;
    assign o_item_out  = r_rd ? w_item_ext[cdq_pkg::ITEM_W-1:0] : '0;
    assign o_finished  = r_fin;
    assign o_count     = r_cnt_out;
    assign o_empty_get = r_emp;
    assign o_full_drop = r_full;

endmodule

>>> sim/cdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_checker
// Watches the request and result ports of the circular deque. It keeps its own
// copy of the ring, the head, the count and both cursors, works out the result
// of every accepted request and compares each strobed result, field by field,
// with the oldest expected one.
// ----------------------------------------------------------------------------
module cdq_checker #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(cdq_pkg::DEPTH_DEF + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [cdq_pkg::KIND_W-1:0]  i_kind,
    input  logic [cdq_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_valid,
    input  logic [cdq_pkg::ITEM_W-1:0]  i_item_out,
    input  logic                        i_finished,
    input  logic [CNT_W-1:0]            i_count,
    input  logic                        i_empty_get,
    input  logic                        i_full_drop,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_full_drops,
    output int                          o_empty_gets
);

    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [cdq_pkg::ITEM_W-1:0] item;
        logic                       finished;
        logic [CNT_W-1:0]           count;
        logic                       empty_get;
        logic                       full_drop;
    } t_deque_result;

    logic [cdq_pkg::VALUE_W-1:0] ring [DEPTH];
    logic [SLOT_W-1:0]  head_slot;
    logic [CNT_W-1:0]   element_count;
    logic [SLOT_W-1:0]  fwd_slot;
    logic               fwd_placed;
    logic [SLOT_W-1:0]  back_slot;
    logic               back_placed;

    t_deque_result expected_results [$];
    int fail_count;
    int checked_count;
    int full_drop_count;
    int empty_get_count;

    function automatic t_deque_result apply_request(
        input logic [cdq_pkg::KIND_W-1:0]  kind,
        input logic [cdq_pkg::VALUE_W-1:0] value);
        t_deque_result     res;
        logic [SLOT_W-1:0] last;
        res  = '0;
        last = head_slot + element_count[SLOT_W-1:0] - 1'b1;
        case (kind)
            cdq_pkg::KIND_PUT_FRONT, cdq_pkg::KIND_PUT_END: begin
                if (element_count >= DEPTH) begin
                    res.full_drop = 1'b1;
                end else if (kind == cdq_pkg::KIND_PUT_FRONT) begin
                    head_slot       = head_slot - 1'b1;
                    ring[head_slot] = value;
                    element_count   = element_count + 1'b1;
                end else begin
                    ring[head_slot + element_count[SLOT_W-1:0]] = value;
                    element_count = element_count + 1'b1;
                end
            end
            cdq_pkg::KIND_FWD_RESTART: fwd_placed = 1'b0;
            cdq_pkg::KIND_BACK_RESTART: back_placed = 1'b0;
            cdq_pkg::KIND_NEXT: begin
                if (element_count == 0) begin
                    res.empty_get = 1'b1;
                end else begin
                    if (!fwd_placed || fwd_slot == last) fwd_slot = head_slot;
                    else fwd_slot = fwd_slot + 1'b1;
                    fwd_placed   = 1'b1;
                    res.item     = ring[fwd_slot];
                    res.finished = (fwd_slot == last);
                end
            end
            cdq_pkg::KIND_PRIOR: begin
                if (element_count == 0) begin
                    res.empty_get = 1'b1;
                end else begin
                    if (!back_placed || back_slot == head_slot) back_slot = last;
                    else back_slot = back_slot - 1'b1;
                    back_placed  = 1'b1;
                    res.item     = ring[back_slot];
                    res.finished = (back_slot == head_slot);
                end
            end
            default: ;
        endcase
        res.count = element_count;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_deque_result want;
        t_deque_result got;
        if (!i_rst_n) begin
            head_slot     = '0;
            element_count = '0;
            fwd_slot      = '0;
            fwd_placed    = 1'b0;
            back_slot     = '0;
            back_placed   = 1'b0;
            expected_results.delete();
        end else begin
            if (i_valid) begin
                got = '{i_item_out, i_finished, i_count, i_empty_get, i_full_drop};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: result with no request waiting: item=%h count=%0d",
                                 $realtime, got.item, got.count);
                end else begin
                    want = expected_results.pop_front();
                    checked_count++;
                    if (want.full_drop) full_drop_count++;
                    if (want.empty_get) empty_get_count++;
                    if (got.item !== want.item || got.finished !== want.finished ||
                        got.count !== want.count || got.empty_get !== want.empty_get ||
                        got.full_drop !== want.full_drop) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX) begin
                            $display("%0t: mismatch, expected item=%h fin=%b count=%0d %s",
                                     $realtime, want.item, want.finished, want.count,
                                     $sformatf("empty=%b full=%b", want.empty_get,
                                               want.full_drop));
                            $display("%0t:           got item=%h fin=%b count=%0d %s",
                                     $realtime, got.item, got.finished, got.count,
                                     $sformatf("empty=%b full=%b", got.empty_get,
                                               got.full_drop));
                        end
                    end
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(apply_request(i_kind, i_value));
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
        o_checked    <= checked_count;
        o_full_drops <= full_drop_count;
        o_empty_gets <= empty_get_count;
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives operation requests into the circular deque: a directed opening on
// empty gets, extreme values, cursor wraps and unused kinds, then random
// requests that fill the ring slowly so that the cursors wrap at many lengths
// before the full case is reached. Results are checked by cdq_checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CNT_W           = $clog2(cdq_pkg::DEPTH_DEF + 1);
    localparam int RANDOM_REQUESTS = 1400;
    localparam int CALM_TAIL       = 150;
    localparam int STALL_LIMIT     = 1000;

    localparam logic [cdq_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [cdq_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd7;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic [cdq_pkg::KIND_W-1:0]  i_kind;
    logic [cdq_pkg::VALUE_W-1:0] i_value;
    logic                        busy;
    logic                        o_valid;
    logic [cdq_pkg::ITEM_W-1:0]  o_item_out;
    logic                        o_finished;
    logic [CNT_W-1:0]            o_count;
    logic                        o_empty_get;
    logic                        o_full_drop;

    int fail_count;
    int pending;
    int checked;
    int full_drops;
    int empty_gets;
    int stall_cycles = 0;

    circular_deque_with_cursors DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_item_out  (o_item_out),
        .o_finished  (o_finished),
        .o_count     (o_count),
        .o_empty_get (o_empty_get),
        .o_full_drop (o_full_drop)
    );

    cdq_checker #(.CNT_W(CNT_W)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .i_valid      (o_valid),
        .i_item_out   (o_item_out),
        .i_finished   (o_finished),
        .i_count      (o_count),
        .i_empty_get  (o_empty_get),
        .i_full_drop  (o_full_drop),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_drops (full_drops),
        .o_empty_gets (empty_gets)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic [cdq_pkg::KIND_W-1:0] kind,
                                input logic [cdq_pkg::VALUE_W-1:0] value);
        start   <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [cdq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        int                         r;
        logic [cdq_pkg::KIND_W-1:0] kind;
        logic                       bursty;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_kind  <= cdq_pkg::KIND_PUT_FRONT;
        i_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, unused kinds, restarts
        send_request(cdq_pkg::KIND_NEXT, 32'h1234_5678);
        send_request(cdq_pkg::KIND_PRIOR, 32'hffff_ffff);
        send_request(KIND_SPARE_A, 32'h5555_5555);
        send_request(KIND_SPARE_B, 32'haaaa_aaaa);
        send_request(cdq_pkg::KIND_FWD_RESTART, '0);
        send_request(cdq_pkg::KIND_BACK_RESTART, '0);
        send_request(cdq_pkg::KIND_PUT_END, 32'h7fff_ffff);
        send_request(cdq_pkg::KIND_PUT_FRONT, 32'h8000_0000);
        send_request(cdq_pkg::KIND_PUT_END, '0);
        send_request(cdq_pkg::KIND_PUT_FRONT, 32'hffff_ffff);
        send_request(cdq_pkg::KIND_PUT_END, 32'h0000_0001);
        // forward walk past the last element
        repeat (6) send_request(cdq_pkg::KIND_NEXT, '0);
        // backward walk past the first element
        repeat (6) send_request(cdq_pkg::KIND_PRIOR, '0);
        send_request(cdq_pkg::KIND_FWD_RESTART, '0);
        send_request(cdq_pkg::KIND_NEXT, '0);
        send_request(cdq_pkg::KIND_BACK_RESTART, '0);
        send_request(cdq_pkg::KIND_PRIOR, '0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 6)
                kind = $urandom_range(0, 1) ? cdq_pkg::KIND_PUT_END : cdq_pkg::KIND_PUT_FRONT;
            else if (r < 9)
                kind = $urandom_range(0, 1) ? KIND_SPARE_B : KIND_SPARE_A;
            else if (r < 15)
                kind = $urandom_range(0, 1) ? cdq_pkg::KIND_BACK_RESTART
                                            : cdq_pkg::KIND_FWD_RESTART;
            else
                kind = $urandom_range(0, 1) ? cdq_pkg::KIND_PRIOR : cdq_pkg::KIND_NEXT;
            bursty = ((n / 200) % 2) == 0;
            if (n == RANDOM_REQUESTS / 2) drain_results();
            else if (n < RANDOM_REQUESTS - CALM_TAIL && bursty && $urandom_range(0, 9) == 0)
                idle_for($urandom_range(1, 18));
            send_request(kind, pick_value());
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        $display("covered %0d results, %0d gets on empty store, %0d puts dropped on full store",
                 checked, empty_gets, full_drops);
        $display("cursor wraps across ring lengths 0 to %0d with wrapping head slot",
                 cdq_pkg::DEPTH_DEF);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
